[rtl/core/ibt_pkg.sv]
`timescale 1ns / 1ps

package ibt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_IDENT,
		MODE_DASH,
		MODE_STR,
		MODE_ESC,
		MODE_ERR
	} mode_t;

	localparam logic [1:0] REC_TEXT  = 2'd0;
	localparam logic [1:0] REC_DONE  = 2'd1;
	localparam logic [1:0] REC_ERROR = 2'd2;

	localparam logic [4:0] TOK_NONE     = 5'd0;
	localparam logic [4:0] TOK_EOF      = 5'd0;
	localparam logic [4:0] TOK_IDENT    = 5'd1;
	localparam logic [4:0] TOK_STRING   = 5'd2;
	localparam logic [4:0] TOK_ARROW    = 5'd3;
	localparam logic [4:0] TOK_LBRACE   = 5'd4;
	localparam logic [4:0] TOK_RBRACE   = 5'd5;
	localparam logic [4:0] TOK_LPAREN   = 5'd6;
	localparam logic [4:0] TOK_RPAREN   = 5'd7;
	localparam logic [4:0] TOK_LBRACKET = 5'd8;
	localparam logic [4:0] TOK_RBRACKET = 5'd9;
	localparam logic [4:0] TOK_COLON    = 5'd10;
	localparam logic [4:0] TOK_COMMA    = 5'd11;
	localparam logic [4:0] TOK_QUESTION = 5'd12;
	localparam logic [4:0] TOK_KW_BASE  = 5'd13;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNTERM     = 2'd1;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_SEMI     = 8'h3B;
	localparam logic [7:0] CH_GT       = 8'h3E;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_UNDER    = 8'h5F;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_N  = 8'h6E;
	localparam logic [7:0] CH_LOWER_T  = 8'h74;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	localparam int NUM_KW = 8;
	localparam int MAX_RECS = 3;
	localparam logic [3:0] MAX_KEYWORD_LEN = 4'd11;
	localparam logic [3:0] WORD_LEN_MAX = 4'd15;

	localparam logic [95:0] KW_STR [NUM_KW] = '{
		96'("module"), 96'("type"), 96'("method"), 96'("event"),
		96'("version"), 96'("description"), 96'("category"), 96'("depends")
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd6, 4'd4, 4'd6, 4'd5, 4'd7, 4'd11, 4'd8, 4'd7
	};

	typedef struct packed {
		logic [1:0] record_kind;
		logic [4:0] token_kind;
		logic [7:0] text_byte;
		logic [1:0] error_code;
	} rec_head_t;

	localparam int HEAD_W = $bits(rec_head_t);

	function automatic rec_head_t mk_head(input logic [1:0] rk, input logic [4:0] tk,
			input logic [7:0] tb, input logic [1:0] err);
		rec_head_t h;
		h.record_kind = rk;
		h.token_kind  = tk;
		h.text_byte   = tb;
		h.error_code  = err;
		return h;
	endfunction

	// Character of keyword k at position pos, or zero beyond its end.
	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
		logic [95:0] s;
		logic [3:0] idx;
		s = KW_STR[k];
		idx = KW_LEN[k] - 4'd1 - pos;
		if (pos < KW_LEN[k]) begin
			s = s >> {idx, 3'b000};
			return s[7:0];
		end else begin
			return CH_NUL;
		end
	endfunction

	function automatic logic [4:0] sym_kind(input logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			CH_LBRACE:   k = TOK_LBRACE;
			CH_RBRACE:   k = TOK_RBRACE;
			CH_LPAREN:   k = TOK_LPAREN;
			CH_RPAREN:   k = TOK_RPAREN;
			CH_LBRACKET: k = TOK_LBRACKET;
			CH_RBRACKET: k = TOK_RBRACKET;
			CH_COLON:    k = TOK_COLON;
			CH_COMMA:    k = TOK_COMMA;
			CH_QUESTION: k = TOK_QUESTION;
			default:     k = TOK_NONE;
		endcase
		return k;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
			(c >= CH_UPPER_A && c <= CH_UPPER_Z) || c == CH_UNDER;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || (c >= CH_ZERO && c <= CH_NINE);
	endfunction

endpackage

[rtl/core/ibt_in_if.sv]
`timescale 1ns / 1ps

interface ibt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       is_end;

	modport source (output valid, output ch, output is_end, input ready);
	modport sink (input valid, input ch, input is_end, output ready);
endinterface

[rtl/core/ibt_out_if.sv]
`timescale 1ns / 1ps

interface ibt_out_if #(
	parameter int POS_BITS = 16
);
	logic                valid;
	logic                ready;
	logic [1:0]          record_kind;
	logic [4:0]          token_kind;
	logic [7:0]          text_byte;
	logic [POS_BITS-1:0] line;
	logic [POS_BITS-1:0] column;
	logic [1:0]          error_code;
	logic                last;

	modport source (output valid, output record_kind, output token_kind, output text_byte,
		output line, output column, output error_code, output last, input ready);
	modport sink (input valid, input record_kind, input token_kind, input text_byte,
		input line, input column, input error_code, input last, output ready);
endinterface

[rtl/core/ibt_front.sv]
`timescale 1ns / 1ps

module ibt_front #(
	parameter int POS_BITS = 16,
	parameter int RW = ibt_pkg::HEAD_W + 2 * POS_BITS,
	parameter int BW = ibt_pkg::MAX_RECS * RW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	ibt_in_if.sink        src,
	input  logic          full,
	output logic          push,
	output logic [BW-1:0] bundle
);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

	ibt_pkg::mode_t mode_q, mode_d;
	logic [POS_BITS-1:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
	logic [POS_BITS-1:0] start_line_q, start_line_d, start_col_q, start_col_d;
	logic [ibt_pkg::NUM_KW-1:0] cand_q, cand_d;
	logic [3:0] wlen_q, wlen_d;

	ibt_pkg::rec_head_t hd [ibt_pkg::MAX_RECS];
	logic [POS_BITS-1:0] ln [ibt_pkg::MAX_RECS];
	logic [POS_BITS-1:0] cl [ibt_pkg::MAX_RECS];
	logic [1:0] n;
	logic [4:0] fin_kind;
	logic [4:0] sym;
	logic [7:0] c, dec;
	logic do_idle, do_word, acc;

	assign acc = src.valid && src.ready;
	assign src.ready = !full;
	assign c = src.ch;

	// The last keyword whose text still matches and whose length fits wins.
	always_comb begin
		fin_kind = ibt_pkg::TOK_IDENT;
		for (int k = 0; k < ibt_pkg::NUM_KW; k++) begin
			if (cand_q[k] && ibt_pkg::KW_LEN[k] == wlen_q) begin
				fin_kind = ibt_pkg::TOK_KW_BASE + 5'(k);
			end
		end
	end

	always_comb begin
		mode_d = mode_q;
		cur_line_d = cur_line_q;
		cur_col_d = cur_col_q;
		start_line_d = start_line_q;
		start_col_d = start_col_q;
		cand_d = cand_q;
		wlen_d = wlen_q;
		n = 2'd0;
		do_idle = 1'b0;
		do_word = 1'b0;
		sym = ibt_pkg::TOK_NONE;
		dec = c;
		for (int i = 0; i < ibt_pkg::MAX_RECS; i++) begin
			hd[i] = '0;
			ln[i] = '0;
			cl[i] = '0;
		end

		if (src.is_end) begin
			unique case (mode_q)
				ibt_pkg::MODE_IDENT: begin
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, fin_kind, ibt_pkg::CH_NUL,
						ibt_pkg::ERR_NONE);
					ln[n] = start_line_q;
					cl[n] = start_col_q;
					n = n + 2'd1;
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, ibt_pkg::TOK_EOF,
						ibt_pkg::CH_NUL, ibt_pkg::ERR_NONE);
					ln[n] = cur_line_q;
					cl[n] = cur_col_q;
					n = n + 2'd1;
				end
				ibt_pkg::MODE_DASH: begin
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE,
						ibt_pkg::CH_DASH, ibt_pkg::ERR_UNEXPECTED);
					ln[n] = start_line_q;
					cl[n] = start_col_q;
					n = n + 2'd1;
				end
				ibt_pkg::MODE_STR, ibt_pkg::MODE_ESC: begin
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE,
						ibt_pkg::CH_NUL, ibt_pkg::ERR_UNTERM);
					ln[n] = cur_line_q;
					cl[n] = cur_col_q;
					n = n + 2'd1;
				end
				ibt_pkg::MODE_ERR: begin
				end
				default: begin
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, ibt_pkg::TOK_EOF,
						ibt_pkg::CH_NUL, ibt_pkg::ERR_NONE);
					ln[n] = cur_line_q;
					cl[n] = cur_col_q;
					n = n + 2'd1;
				end
			endcase
			mode_d = ibt_pkg::MODE_IDLE;
			cur_line_d = POS_ONE;
			cur_col_d = POS_ONE;
			start_line_d = POS_ONE;
			start_col_d = POS_ONE;
			cand_d = '1;
			wlen_d = 4'd0;
		end else begin
			unique case (mode_q)
				ibt_pkg::MODE_COMMENT: begin
					if (c == ibt_pkg::CH_LF) begin
						if (cur_line_d != POS_MAX) cur_line_d = cur_line_d + POS_ONE;
						cur_col_d = POS_ONE;
						mode_d = ibt_pkg::MODE_IDLE;
					end
				end
				ibt_pkg::MODE_DASH: begin
					if (c == ibt_pkg::CH_GT) begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE,
							ibt_pkg::CH_DASH, ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE,
							ibt_pkg::CH_GT, ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, ibt_pkg::TOK_ARROW,
							ibt_pkg::CH_NUL, ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
						mode_d = ibt_pkg::MODE_IDLE;
					end else begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE,
							ibt_pkg::CH_DASH, ibt_pkg::ERR_UNEXPECTED);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						mode_d = ibt_pkg::MODE_ERR;
					end
				end
				ibt_pkg::MODE_STR: begin
					if (c == ibt_pkg::CH_QUOTE) begin
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, ibt_pkg::TOK_STRING,
							ibt_pkg::CH_NUL, ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						mode_d = ibt_pkg::MODE_IDLE;
					end else if (c == ibt_pkg::CH_LF) begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE, c,
							ibt_pkg::ERR_UNTERM);
						ln[n] = cur_line_q;
						cl[n] = cur_col_q;
						n = n + 2'd1;
						mode_d = ibt_pkg::MODE_ERR;
					end else if (c == ibt_pkg::CH_BSLASH) begin
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
						mode_d = ibt_pkg::MODE_ESC;
					end else begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c,
							ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
					end
				end
				ibt_pkg::MODE_ESC: begin
					if (c == ibt_pkg::CH_LOWER_N) dec = ibt_pkg::CH_LF;
					else if (c == ibt_pkg::CH_LOWER_T) dec = ibt_pkg::CH_TAB;
					hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, dec,
						ibt_pkg::ERR_NONE);
					ln[n] = start_line_q;
					cl[n] = start_col_q;
					n = n + 2'd1;
					if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
					mode_d = ibt_pkg::MODE_STR;
				end
				ibt_pkg::MODE_IDENT: begin
					if (ibt_pkg::is_word(c)) begin
						do_word = 1'b1;
					end else begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, fin_kind, ibt_pkg::CH_NUL,
							ibt_pkg::ERR_NONE);
						ln[n] = start_line_q;
						cl[n] = start_col_q;
						n = n + 2'd1;
						mode_d = ibt_pkg::MODE_IDLE;
						do_idle = 1'b1;
					end
				end
				ibt_pkg::MODE_ERR: begin
				end
				default: begin
					mode_d = ibt_pkg::MODE_IDLE;
					do_idle = 1'b1;
				end
			endcase

			if (do_idle) begin
				if (c == ibt_pkg::CH_SPACE || c == ibt_pkg::CH_TAB || c == ibt_pkg::CH_CR) begin
					if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
				end else if (c == ibt_pkg::CH_LF) begin
					if (cur_line_d != POS_MAX) cur_line_d = cur_line_d + POS_ONE;
					cur_col_d = POS_ONE;
				end else if (c == ibt_pkg::CH_SEMI) begin
					mode_d = ibt_pkg::MODE_COMMENT;
				end else begin
					start_line_d = cur_line_d;
					start_col_d = cur_col_d;
					sym = ibt_pkg::sym_kind(c);
					if (sym != ibt_pkg::TOK_NONE) begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c,
							ibt_pkg::ERR_NONE);
						ln[n] = start_line_d;
						cl[n] = start_col_d;
						n = n + 2'd1;
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_DONE, sym, ibt_pkg::CH_NUL,
							ibt_pkg::ERR_NONE);
						ln[n] = start_line_d;
						cl[n] = start_col_d;
						n = n + 2'd1;
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
					end else if (c == ibt_pkg::CH_DASH) begin
						mode_d = ibt_pkg::MODE_DASH;
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
					end else if (c == ibt_pkg::CH_QUOTE) begin
						mode_d = ibt_pkg::MODE_STR;
						if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
					end else if (ibt_pkg::is_alpha(c)) begin
						cand_d = '1;
						wlen_d = 4'd0;
						mode_d = ibt_pkg::MODE_IDENT;
						do_word = 1'b1;
					end else begin
						hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE, c,
							ibt_pkg::ERR_UNEXPECTED);
						ln[n] = cur_line_d;
						cl[n] = cur_col_d;
						n = n + 2'd1;
						mode_d = ibt_pkg::MODE_ERR;
					end
				end
			end

			if (do_word) begin
				for (int k = 0; k < ibt_pkg::NUM_KW; k++) begin
					if (wlen_d >= ibt_pkg::KW_LEN[k] || ibt_pkg::kw_char(3'(k), wlen_d) != c) begin
						cand_d[k] = 1'b0;
					end
				end
				if (wlen_d != ibt_pkg::WORD_LEN_MAX) wlen_d = wlen_d + 4'd1;
				if (wlen_d > ibt_pkg::MAX_KEYWORD_LEN) cand_d = '0;
				hd[n] = ibt_pkg::mk_head(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c,
					ibt_pkg::ERR_NONE);
				ln[n] = start_line_d;
				cl[n] = start_col_d;
				n = n + 2'd1;
				if (cur_col_d != POS_MAX) cur_col_d = cur_col_d + POS_ONE;
			end
		end
	end

	always_comb begin
		bundle = '0;
		for (int i = 0; i < ibt_pkg::MAX_RECS; i++) begin
			bundle[i*RW +: RW] = {hd[i], ln[i], cl[i]};
		end
		bundle[ibt_pkg::MAX_RECS*RW +: 2] = n;
	end

	assign push = acc && n != 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ibt_pkg::MODE_IDLE;
			cur_line_q <= POS_ONE;
			cur_col_q <= POS_ONE;
			start_line_q <= POS_ONE;
			start_col_q <= POS_ONE;
			cand_q <= '1;
			wlen_q <= 4'd0;
		end else if (acc) begin
			mode_q <= mode_d;
			cur_line_q <= cur_line_d;
			cur_col_q <= cur_col_d;
			start_line_q <= start_line_d;
			start_col_q <= start_col_d;
			cand_q <= cand_d;
			wlen_q <= wlen_d;
		end
	end

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ibt_pkg::MODE_ERR && !(acc && src.is_end)) |=> mode_q == ibt_pkg::MODE_ERR)
		else $error("error state left without an end marker");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && src.is_end) |=> (mode_q == ibt_pkg::MODE_IDLE && cur_line_q == POS_ONE &&
		cur_col_q == POS_ONE && wlen_q == 4'd0))
		else $error("end marker did not return the state to its start");

endmodule

[rtl/core/ibt_queue.sv]
`timescale 1ns / 1ps

module ibt_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("read from an empty queue");

endmodule

[rtl/core/ibt_back.sv]
`timescale 1ns / 1ps

module ibt_back #(
	parameter int POS_BITS = 16,
	parameter int RW = ibt_pkg::HEAD_W + 2 * POS_BITS,
	parameter int BW = ibt_pkg::MAX_RECS * RW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [BW-1:0] bundle,
	input  logic          empty,
	output logic          pop,
	ibt_out_if.source     res
);

	logic [1:0] idx_q;
	logic [1:0] cnt;
	logic [RW-1:0] rec;
	logic load, is_last, vld_q;
	ibt_pkg::rec_head_t head;
	logic [POS_BITS-1:0] rec_line, rec_col;

	assign cnt = bundle[ibt_pkg::MAX_RECS*RW +: 2];

	always_comb begin
		unique case (idx_q)
			2'd1:    rec = bundle[RW +: RW];
			2'd2:    rec = bundle[2*RW +: RW];
			default: rec = bundle[RW-1:0];
		endcase
	end

	assign {head, rec_line, rec_col} = rec;
	assign load = !vld_q || res.ready;
	assign is_last = idx_q == cnt - 2'd1;
	assign pop = load && !empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			vld_q <= !empty;
			if (!empty) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			res.record_kind <= head.record_kind;
			res.token_kind <= head.token_kind;
			res.text_byte <= head.text_byte;
			res.error_code <= head.error_code;
			res.line <= rec_line;
			res.column <= rec_col;
			res.last <= is_last;
		end
	end

	assign res.valid = vld_q;

	a_idx_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cnt != 2'd0 && idx_q < cnt))
		else $error("record index beyond the queued group");

endmodule

[rtl/core/idl_byte_tokenizer_unit.sv]
`timescale 1ns / 1ps

// Byte tokenizer for an interface-description source.
// The src channel takes one source word per cycle: a byte in ch, or an end
// marker with is_end high. The res channel gives the records each word causes: token
// text bytes, token-complete records with the start line and column, and
// error records; last marks the final record caused by one source word.
// The front part decodes a source word in the cycle it is accepted and puts
// the zero to three records it causes into a queue of QUEUE_DEPTH groups.
// The back part drains the queue into an output register, one record per
// cycle while the receiver is ready, so a word's records pass the queue
// and then that register. A source word is taken every cycle while the
// queue has room; the sustained rate is one word per cycle as long as the
// words average no more than one record each, and is otherwise set by the
// one-record-per-cycle output register. When the receiver stalls, the output
// holds and the queue fills, after which src.ready drops. Reset returns the
// position to line 1, column 1, empties the queue and clears res.valid.

module idl_byte_tokenizer_unit #(
	parameter int POS_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	ibt_in_if.sink    src,
	ibt_out_if.source res
);

	localparam int RW = ibt_pkg::HEAD_W + 2 * POS_BITS;
	localparam int BW = ibt_pkg::MAX_RECS * RW + 2;

	logic push, pop, full, empty;
	logic [BW-1:0] wr_bundle, rd_bundle;

	ibt_front #(
		.POS_BITS(POS_BITS),
		.RW(RW),
		.BW(BW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.src(src),
		.full(full),
		.push(push),
		.bundle(wr_bundle)
	);

	ibt_queue #(
		.W(BW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wr_bundle),
		.pop(pop),
		.rdata(rd_bundle),
		.full(full),
		.empty(empty)
	);

	ibt_back #(
		.POS_BITS(POS_BITS),
		.RW(RW),
		.BW(BW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.bundle(rd_bundle),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

endmodule

[dv/idl_byte_tokenizer_unit_test.sv]
`timescale 1ns / 1ps

module idl_byte_tokenizer_unit_test;

	typedef struct packed {
		logic [1:0]  rk;
		logic [4:0]  tk;
		logic [7:0]  tb;
		logic [15:0] ln;
		logic [15:0] col;
		logic [1:0]  err;
		logic        last;
	} tok_rec_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
		logic       typed;
		tok_rec_t   want;
	} src_word_t;

	localparam int IDLE_PCT = 30;
	localparam int RANDOM_WORDS = 120;
	localparam int CALM_WORDS = 40;
	localparam logic [15:0] POS_TOP = 16'hFFFF;
	localparam logic [7:0] SYMBOLS [9] = '{ibt_pkg::CH_LBRACE, ibt_pkg::CH_RBRACE,
		ibt_pkg::CH_LPAREN, ibt_pkg::CH_RPAREN, ibt_pkg::CH_LBRACKET, ibt_pkg::CH_RBRACKET,
		ibt_pkg::CH_COLON, ibt_pkg::CH_COMMA, ibt_pkg::CH_QUESTION};
	localparam logic [7:0] BLANKS [4] = '{ibt_pkg::CH_SPACE, ibt_pkg::CH_TAB, ibt_pkg::CH_CR,
		ibt_pkg::CH_LF};

	logic clk;
	logic arst_n;
	logic calm;
	logic src_taken;
	int   bad_recs;
	int   gen_count;

	ibt_in_if src_bus ();
	ibt_out_if #(.POS_BITS(16)) res_bus ();

	idl_byte_tokenizer_unit #(.POS_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_bus),
		.res(res_bus)
	);

	ibt_pkg::mode_t tk_mode;
	logic [15:0] tk_line;
	logic [15:0] tk_col;
	logic [15:0] tk_start_line;
	logic [15:0] tk_start_col;
	logic [7:0]  tk_cands;
	logic [3:0]  tk_wlen;

	tok_rec_t  step_recs [$];
	tok_rec_t  rec_q [$];
	src_word_t src_q [$];

	function automatic string kw_word(input int k);
		case (k)
			0: return "module";
			1: return "type";
			2: return "method";
			3: return "event";
			4: return "version";
			5: return "description";
			6: return "category";
			default: return "depends";
		endcase
	endfunction

	function automatic logic ident_head(input logic [7:0] c);
		return (c >= ibt_pkg::CH_LOWER_A && c <= ibt_pkg::CH_LOWER_Z) ||
			(c >= ibt_pkg::CH_UPPER_A && c <= ibt_pkg::CH_UPPER_Z) || c == ibt_pkg::CH_UNDER;
	endfunction

	function automatic logic ident_tail(input logic [7:0] c);
		return ident_head(c) || (c >= ibt_pkg::CH_ZERO && c <= ibt_pkg::CH_NINE);
	endfunction

	function automatic logic [4:0] symbol_of(input logic [7:0] c);
		case (c)
			ibt_pkg::CH_LBRACE:   return ibt_pkg::TOK_LBRACE;
			ibt_pkg::CH_RBRACE:   return ibt_pkg::TOK_RBRACE;
			ibt_pkg::CH_LPAREN:   return ibt_pkg::TOK_LPAREN;
			ibt_pkg::CH_RPAREN:   return ibt_pkg::TOK_RPAREN;
			ibt_pkg::CH_LBRACKET: return ibt_pkg::TOK_LBRACKET;
			ibt_pkg::CH_RBRACKET: return ibt_pkg::TOK_RBRACKET;
			ibt_pkg::CH_COLON:    return ibt_pkg::TOK_COLON;
			ibt_pkg::CH_COMMA:    return ibt_pkg::TOK_COMMA;
			ibt_pkg::CH_QUESTION: return ibt_pkg::TOK_QUESTION;
			default:              return ibt_pkg::TOK_NONE;
		endcase
	endfunction

	function automatic string rec_text(input tok_rec_t r);
		return $sformatf("kind=%0d token=%0d byte=%02h line=%0d col=%0d err=%0d last=%0b",
			r.rk, r.tk, r.tb, r.ln, r.col, r.err, r.last);
	endfunction

	function automatic src_word_t src_word(input logic [7:0] c, input logic e);
		src_word_t w;
		w = '0;
		w.ch = c;
		w.is_end = e;
		return w;
	endfunction

	function automatic src_word_t src_word_exp(input logic [7:0] c, input logic e,
			input logic [1:0] rk, input logic [4:0] tk, input logic [7:0] tb,
			input logic [15:0] ln, input logic [15:0] col, input logic [1:0] err);
		src_word_t w;
		w = src_word(c, e);
		w.typed = 1'b1;
		w.want.rk = rk;
		w.want.tk = tk;
		w.want.tb = tb;
		w.want.ln = ln;
		w.want.col = col;
		w.want.err = err;
		w.want.last = 1'b1;
		return w;
	endfunction

	task automatic clear_position();
		tk_mode = ibt_pkg::MODE_IDLE;
		tk_line = 16'd1;
		tk_col = 16'd1;
		tk_start_line = 16'd1;
		tk_start_col = 16'd1;
		tk_cands = 8'hFF;
		tk_wlen = 4'd0;
	endtask

	task automatic note_rec(input logic [1:0] rk, input logic [4:0] tk, input logic [7:0] tb,
			input logic [15:0] ln, input logic [15:0] col, input logic [1:0] err);
		tok_rec_t r;
		r.rk = rk;
		r.tk = tk;
		r.tb = tb;
		r.ln = ln;
		r.col = col;
		r.err = err;
		r.last = 1'b0;
		step_recs = {step_recs, r};
	endtask

	task automatic step_col();
		if (tk_col != POS_TOP) begin
			tk_col = tk_col + 16'd1;
		end
	endtask

	task automatic new_line();
		if (tk_line != POS_TOP) begin
			tk_line = tk_line + 16'd1;
		end
		tk_col = 16'd1;
	endtask

	task automatic raise_error(input logic [1:0] code, input logic [7:0] b,
			input logic [15:0] ln, input logic [15:0] col);
		note_rec(ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE, b, ln, col, code);
		tk_mode = ibt_pkg::MODE_ERR;
	endtask

	task automatic take_word_byte(input logic [7:0] c);
		string w;
		for (int k = 0; k < ibt_pkg::NUM_KW; k++) begin
			w = kw_word(k);
			if (int'(tk_wlen) >= w.len()) begin
				tk_cands[k] = 1'b0;
			end else if (8'(w[tk_wlen]) != c) begin
				tk_cands[k] = 1'b0;
			end
		end
		if (tk_wlen != ibt_pkg::WORD_LEN_MAX) begin
			tk_wlen = tk_wlen + 4'd1;
		end
		if (tk_wlen > ibt_pkg::MAX_KEYWORD_LEN) begin
			tk_cands = '0;
		end
		note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c, tk_start_line, tk_start_col,
			ibt_pkg::ERR_NONE);
		step_col();
	endtask

	task automatic close_word();
		logic [4:0] kind;
		string w;
		kind = ibt_pkg::TOK_IDENT;
		for (int k = 0; k < ibt_pkg::NUM_KW; k++) begin
			w = kw_word(k);
			if (tk_cands[k] && w.len() == int'(tk_wlen)) begin
				kind = ibt_pkg::TOK_KW_BASE + 5'(k);
			end
		end
		note_rec(ibt_pkg::REC_DONE, kind, ibt_pkg::CH_NUL, tk_start_line, tk_start_col,
			ibt_pkg::ERR_NONE);
		tk_mode = ibt_pkg::MODE_IDLE;
	endtask

	task automatic scan_idle_byte(input logic [7:0] c);
		logic [4:0] sym;
		sym = symbol_of(c);
		if (c == ibt_pkg::CH_SPACE || c == ibt_pkg::CH_TAB || c == ibt_pkg::CH_CR) begin
			step_col();
		end else if (c == ibt_pkg::CH_LF) begin
			new_line();
		end else if (c == ibt_pkg::CH_SEMI) begin
			tk_mode = ibt_pkg::MODE_COMMENT;
		end else begin
			tk_start_line = tk_line;
			tk_start_col = tk_col;
			if (sym != ibt_pkg::TOK_NONE) begin
				note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c, tk_start_line, tk_start_col,
					ibt_pkg::ERR_NONE);
				note_rec(ibt_pkg::REC_DONE, sym, ibt_pkg::CH_NUL, tk_start_line, tk_start_col,
					ibt_pkg::ERR_NONE);
				step_col();
			end else if (c == ibt_pkg::CH_DASH) begin
				tk_mode = ibt_pkg::MODE_DASH;
				step_col();
			end else if (c == ibt_pkg::CH_QUOTE) begin
				tk_mode = ibt_pkg::MODE_STR;
				step_col();
			end else if (ident_head(c)) begin
				tk_cands = 8'hFF;
				tk_wlen = 4'd0;
				tk_mode = ibt_pkg::MODE_IDENT;
				take_word_byte(c);
			end else begin
				raise_error(ibt_pkg::ERR_UNEXPECTED, c, tk_line, tk_col);
			end
		end
	endtask

	task automatic tokenize_word(input logic [7:0] c, input logic e);
		logic [7:0] d;
		step_recs.delete();
		if (e) begin
			case (tk_mode)
				ibt_pkg::MODE_IDENT: begin
					close_word();
					note_rec(ibt_pkg::REC_DONE, ibt_pkg::TOK_EOF, ibt_pkg::CH_NUL, tk_line, tk_col,
						ibt_pkg::ERR_NONE);
				end
				ibt_pkg::MODE_DASH: begin
					raise_error(ibt_pkg::ERR_UNEXPECTED, ibt_pkg::CH_DASH, tk_start_line,
						tk_start_col);
				end
				ibt_pkg::MODE_STR, ibt_pkg::MODE_ESC: begin
					raise_error(ibt_pkg::ERR_UNTERM, ibt_pkg::CH_NUL, tk_line, tk_col);
				end
				ibt_pkg::MODE_ERR: begin
				end
				default: begin
					note_rec(ibt_pkg::REC_DONE, ibt_pkg::TOK_EOF, ibt_pkg::CH_NUL, tk_line, tk_col,
						ibt_pkg::ERR_NONE);
				end
			endcase
			clear_position();
		end else begin
			case (tk_mode)
				ibt_pkg::MODE_COMMENT: begin
					if (c == ibt_pkg::CH_LF) begin
						new_line();
						tk_mode = ibt_pkg::MODE_IDLE;
					end
				end
				ibt_pkg::MODE_DASH: begin
					if (c == ibt_pkg::CH_GT) begin
						note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, ibt_pkg::CH_DASH,
							tk_start_line, tk_start_col, ibt_pkg::ERR_NONE);
						note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, ibt_pkg::CH_GT,
							tk_start_line, tk_start_col, ibt_pkg::ERR_NONE);
						note_rec(ibt_pkg::REC_DONE, ibt_pkg::TOK_ARROW, ibt_pkg::CH_NUL,
							tk_start_line, tk_start_col, ibt_pkg::ERR_NONE);
						step_col();
						tk_mode = ibt_pkg::MODE_IDLE;
					end else begin
						raise_error(ibt_pkg::ERR_UNEXPECTED, ibt_pkg::CH_DASH, tk_start_line,
							tk_start_col);
					end
				end
				ibt_pkg::MODE_STR: begin
					if (c == ibt_pkg::CH_QUOTE) begin
						step_col();
						note_rec(ibt_pkg::REC_DONE, ibt_pkg::TOK_STRING, ibt_pkg::CH_NUL,
							tk_start_line, tk_start_col, ibt_pkg::ERR_NONE);
						tk_mode = ibt_pkg::MODE_IDLE;
					end else if (c == ibt_pkg::CH_LF) begin
						raise_error(ibt_pkg::ERR_UNTERM, c, tk_line, tk_col);
					end else if (c == ibt_pkg::CH_BSLASH) begin
						step_col();
						tk_mode = ibt_pkg::MODE_ESC;
					end else begin
						note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, c, tk_start_line,
							tk_start_col, ibt_pkg::ERR_NONE);
						step_col();
					end
				end
				ibt_pkg::MODE_ESC: begin
					d = c;
					if (c == ibt_pkg::CH_LOWER_N) begin
						d = ibt_pkg::CH_LF;
					end else if (c == ibt_pkg::CH_LOWER_T) begin
						d = ibt_pkg::CH_TAB;
					end
					note_rec(ibt_pkg::REC_TEXT, ibt_pkg::TOK_NONE, d, tk_start_line, tk_start_col,
						ibt_pkg::ERR_NONE);
					step_col();
					tk_mode = ibt_pkg::MODE_STR;
				end
				ibt_pkg::MODE_IDENT: begin
					if (ident_tail(c)) begin
						take_word_byte(c);
					end else begin
						close_word();
						scan_idle_byte(c);
					end
				end
				ibt_pkg::MODE_ERR: begin
				end
				default: begin
					tk_mode = ibt_pkg::MODE_IDLE;
					scan_idle_byte(c);
				end
			endcase
		end
		if (step_recs.size() > 0) begin
			step_recs[step_recs.size() - 1].last = 1'b1;
		end
	endtask

	task automatic queue_byte(input logic [7:0] c);
		src_q = {src_q, src_word(c, 1'b0)};
		gen_count++;
	endtask

	task automatic queue_end();
		src_q = {src_q, src_word(8'($urandom_range(255)), 1'b1)};
		gen_count++;
	endtask

	function automatic logic [7:0] rand_head_char();
		int r;
		r = $urandom_range(52);
		if (r < 26) begin
			return ibt_pkg::CH_LOWER_A + 8'(r);
		end else if (r < 52) begin
			return ibt_pkg::CH_UPPER_A + 8'(r - 26);
		end
		return ibt_pkg::CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_tail_char();
		if ($urandom_range(3) == 0) begin
			return ibt_pkg::CH_ZERO + 8'($urandom_range(9));
		end
		return rand_head_char();
	endfunction

	function automatic logic [7:0] rand_plain_byte();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == ibt_pkg::CH_QUOTE || c == ibt_pkg::CH_BSLASH || c == ibt_pkg::CH_LF) begin
			c = ibt_pkg::CH_SPACE;
		end
		return c;
	endfunction

	task automatic queue_source_file();
		int ntok;
		int pick;
		int len;
		string w;
		logic open_ident;
		ntok = $urandom_range(10, 2);
		for (int t = 0; t < ntok; t++) begin
			pick = $urandom_range(99);
			open_ident = 1'b0;
			if (pick < 22) begin
				w = kw_word($urandom_range(ibt_pkg::NUM_KW - 1));
				for (int i = 0; i < w.len(); i++) begin
					queue_byte(8'(w[i]));
				end
				if ($urandom_range(3) == 0) begin
					queue_byte(rand_tail_char());
				end
				open_ident = 1'b1;
			end else if (pick < 36) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
				queue_byte(rand_head_char());
				for (int i = 1; i < len; i++) begin
					queue_byte(rand_tail_char());
				end
				open_ident = 1'b1;
			end else if (pick < 50) begin
				queue_byte(SYMBOLS[$urandom_range(8)]);
			end else if (pick < 58) begin
				queue_byte(ibt_pkg::CH_DASH);
				queue_byte(ibt_pkg::CH_GT);
			end else if (pick < 72) begin
				queue_byte(ibt_pkg::CH_QUOTE);
				len = $urandom_range(6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(4) == 0) begin
						queue_byte(ibt_pkg::CH_BSLASH);
						case ($urandom_range(5))
							0: queue_byte(ibt_pkg::CH_LOWER_N);
							1: queue_byte(ibt_pkg::CH_LOWER_T);
							2: queue_byte(ibt_pkg::CH_BSLASH);
							3: queue_byte(ibt_pkg::CH_QUOTE);
							4: queue_byte(ibt_pkg::CH_LF);
							default: queue_byte(8'($urandom_range(255)));
						endcase
					end else begin
						queue_byte(rand_plain_byte());
					end
				end
				queue_byte(ibt_pkg::CH_QUOTE);
			end else if (pick < 84) begin
				queue_byte(BLANKS[$urandom_range(3)]);
			end else begin
				queue_byte(ibt_pkg::CH_SEMI);
				len = $urandom_range(5);
				for (int i = 0; i < len; i++) begin
					queue_byte(rand_plain_byte());
				end
				queue_byte(ibt_pkg::CH_LF);
			end
			if (open_ident && (t < ntok - 1 || $urandom_range(1) == 0)) begin
				case ($urandom_range(5))
					4: queue_byte(SYMBOLS[$urandom_range(8)]);
					5: begin
						queue_byte(ibt_pkg::CH_DASH);
						queue_byte(ibt_pkg::CH_GT);
					end
					default: queue_byte(BLANKS[$urandom_range(3)]);
				endcase
			end
		end
		// Broken endings are kept to the tail of a file, as the block discards the rest.
		if ($urandom_range(99) < 18) begin
			case ($urandom_range(5))
				0: queue_byte(8'($urandom_range(255)));
				1: begin
					queue_byte(ibt_pkg::CH_DASH);
					queue_byte(8'($urandom_range(255)));
				end
				2: begin
					queue_byte(ibt_pkg::CH_QUOTE);
					queue_byte(rand_plain_byte());
					queue_byte(ibt_pkg::CH_LF);
				end
				3: begin
					queue_byte(ibt_pkg::CH_QUOTE);
					queue_byte(rand_plain_byte());
				end
				4: queue_byte(ibt_pkg::CH_DASH);
				default: begin
					queue_byte(ibt_pkg::CH_QUOTE);
					queue_byte(ibt_pkg::CH_BSLASH);
				end
			endcase
		end
		queue_end();
	endtask

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		tok_rec_t got;
		tok_rec_t want;
		src_word_t w;
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				got.rk = res_bus.record_kind;
				got.tk = res_bus.token_kind;
				got.tb = res_bus.text_byte;
				got.ln = res_bus.line;
				got.col = res_bus.column;
				got.err = res_bus.error_code;
				got.last = res_bus.last;
				if (rec_q.size() == 0) begin
					if (bad_recs < 10) begin
						$display("unexpected record: %s", rec_text(got));
					end
					bad_recs++;
				end else begin
					want = rec_q.pop_front();
					if (got.rk !== want.rk || got.tk !== want.tk || got.tb !== want.tb ||
							got.ln !== want.ln || got.col !== want.col ||
							got.err !== want.err || got.last !== want.last) begin
						if (bad_recs < 10) begin
							$display("record mismatch: expected %s", rec_text(want));
							$display("                 got      %s", rec_text(got));
						end
						bad_recs++;
					end
				end
			end
			if (src_bus.valid && src_bus.ready) begin
				w = src_q.pop_front();
				src_taken = 1'b1;
				tokenize_word(src_bus.ch, src_bus.is_end);
				if (w.typed) begin
					rec_q = {rec_q, w.want};
				end else begin
					rec_q = {rec_q, step_recs};
					step_recs.delete();
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!src_bus.valid || src_taken) begin
			src_taken = 1'b0;
			if (src_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				src_bus.valid <= 1'b1;
				src_bus.ch <= src_q[0].ch;
				src_bus.is_end <= src_q[0].is_end;
			end else begin
				src_bus.valid <= 1'b0;
			end
		end
		res_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	initial begin
		src_word_t dir_rows [$];
		arst_n = 1'b0;
		calm = 1'b0;
		src_taken = 1'b0;
		bad_recs = 0;
		gen_count = 0;
		src_bus.valid = 1'b0;
		src_bus.ch = ibt_pkg::CH_NUL;
		src_bus.is_end = 1'b0;
		res_bus.ready = 1'b0;
		clear_position();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		dir_rows = {
			src_word_exp(8'hFF, 1'b1, ibt_pkg::REC_DONE, ibt_pkg::TOK_EOF, ibt_pkg::CH_NUL,
				16'd1, 16'd1, ibt_pkg::ERR_NONE),
			src_word_exp("@", 1'b0, ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE, "@",
				16'd1, 16'd1, ibt_pkg::ERR_UNEXPECTED),
			src_word(8'hFF, 1'b1),
			src_word(ibt_pkg::CH_DASH, 1'b0),
			src_word(ibt_pkg::CH_GT, 1'b0),
			src_word(ibt_pkg::CH_LBRACE, 1'b0),
			src_word(ibt_pkg::CH_SEMI, 1'b0),
			src_word(8'h00, 1'b0),
			src_word(ibt_pkg::CH_LF, 1'b0),
			src_word(ibt_pkg::CH_QUOTE, 1'b0),
			src_word(ibt_pkg::CH_BSLASH, 1'b0),
			src_word(ibt_pkg::CH_LOWER_N, 1'b0),
			src_word(ibt_pkg::CH_BSLASH, 1'b0),
			src_word(ibt_pkg::CH_LF, 1'b0),
			src_word(ibt_pkg::CH_QUOTE, 1'b0),
			src_word(ibt_pkg::CH_UNDER, 1'b0),
			src_word(ibt_pkg::CH_NINE, 1'b0),
			src_word(ibt_pkg::CH_QUESTION, 1'b0),
			src_word(ibt_pkg::CH_DASH, 1'b0),
			src_word(ibt_pkg::CH_DASH, 1'b0),
			src_word(8'h00, 1'b1),
			src_word(ibt_pkg::CH_QUOTE, 1'b0),
			src_word_exp(8'h00, 1'b1, ibt_pkg::REC_ERROR, ibt_pkg::TOK_NONE, ibt_pkg::CH_NUL,
				16'd1, 16'd2, ibt_pkg::ERR_UNTERM),
			src_word(ibt_pkg::CH_QUOTE, 1'b0),
			src_word(ibt_pkg::CH_LF, 1'b0),
			src_word(8'hFF, 1'b1)
		};
		src_q = {src_q, dir_rows};

		gen_count = 0;
		while (gen_count < RANDOM_WORDS) begin
			queue_source_file();
		end
		while (src_q.size() > 0) begin
			@(posedge clk);
		end

		// A stretch with no idling on either side.
		calm = 1'b1;
		gen_count = 0;
		while (gen_count < CALM_WORDS) begin
			queue_source_file();
		end
		while (src_q.size() > 0) begin
			@(posedge clk);
		end
		calm = 1'b0;

		while (rec_q.size() > 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (bad_recs == 0 && rec_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#100000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/ibt_pkg.sv
rtl/core/ibt_in_if.sv
rtl/core/ibt_out_if.sv
rtl/core/ibt_front.sv
rtl/core/ibt_queue.sv
rtl/core/ibt_back.sv
rtl/core/idl_byte_tokenizer_unit.sv
dv/idl_byte_tokenizer_unit_test.sv
